/* hw/rtl/rmd_pkg.sv */
// shared constants and types for the rate monotonic dispatcher
package rmd_pkg;
  localparam int unsigned MaxTasks = 8;
  localparam int unsigned IdxW = $clog2(MaxTasks);
  localparam int unsigned CntW = $clog2(MaxTasks + 1);

  localparam logic ActLoad = 1'b0;
  localparam logic ActTick = 1'b1;

  typedef struct packed {
    logic [15:0] burst;
    logic [15:0] period;
    logic [15:0] rel_left;
    logic [15:0] work;
    logic [31:0] deadline;
    logic [31:0] rel_time;
  } task_entry_t;
endpackage

/* hw/rtl/rate_monotonic_dispatcher_unit.sv */
// top level of the rate monotonic dispatcher with its tick sequencer
// A load item writes its entry in the accepting cycle and then holds its
// result in StOut. A tick item walks the task table with one shared compare
// and update path, one entry per cycle, in three passes (release, pick, drop;
// skipped when no entry is active), then runs the chosen job in StRun and
// presents the result in StOut. The result is held in an output register; the
// block takes no new item until it has been read. A register write waiting at
// the same time as an item goes first.
module rate_monotonic_dispatcher_unit import rmd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [2:0]  task_index_i,
  input  logic [15:0] burst_time_i,
  input  logic [15:0] period_i,
  input  logic [15:0] release_count_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  running_task_o,
  output logic        idle_o,
  output logic        job_finished_o,
  output logic [31:0] job_wait_o,
  output logic [3:0]  missed_now_o,
  output logic [31:0] missed_total_o,
  output logic [31:0] current_time_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_data_i
);
  typedef enum logic [2:0] {
    StIdle, StRel, StPick, StDrop, StRun, StOut
  } state_e;

  state_e state_q;
  logic [IdxW-1:0] idx_q, pick_q;
  logic have_q;
  logic [15:0] pick_per_q;
  logic [3:0] tc_q, miss_now_q;
  logic [31:0] now_q, miss_tot_q;
  logic [2:0] run_q;
  logic idle_q, fin_q;
  logic [31:0] wait_q;

  // table port
  logic we;
  logic [IdxW-1:0] waddr, raddr;
  task_entry_t wdata, rd;

  rmd_task_table u_table (
    .clk_i, .rst_ni, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rd)
  );

  // active entry count, clipped to the table depth
  logic [CntW-1:0] n_act;
  always_comb begin
    if ({28'd0, tc_q} > 32'(MaxTasks)) n_act = CntW'(MaxTasks);
    else n_act = CntW'(tc_q);
  end
  logic last;
  assign last = (CntW'(idx_q) + CntW'(1)) >= n_act;

  logic [IdxW-1:0] load_idx;
  logic load_ok;
  assign load_idx = IdxW'(task_index_i);
  assign load_ok = {29'd0, task_index_i} < 32'(MaxTasks);

  // a pending register write holds off the item
  assign in_ready_o = (state_q == StIdle) && !cfg_valid_i;
  assign cfg_ready_o = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);

  logic in_fire;
  assign in_fire = in_valid_i && in_ready_o;

  // deadline test: now + work > deadline, in 33 bits
  logic late;
  assign late = ({1'b0, now_q} + {17'd0, rd.work}) > {1'b0, rd.deadline};

  logic [31:0] miss_inc;
  assign miss_inc = (miss_tot_q != '1) ? miss_tot_q + 32'd1 : miss_tot_q;
  logic [3:0] now_inc;
  assign now_inc = (miss_now_q != 4'd15) ? miss_now_q + 4'd1 : miss_now_q;

  always_comb begin
    we = 1'b0;
    waddr = idx_q;
    raddr = idx_q;
    wdata = rd;
    case (state_q)
      StIdle: begin
        waddr = load_idx;
        wdata.burst = burst_time_i;
        wdata.period = period_i;
        wdata.rel_left = release_count_i;
        wdata.work = '0;
        wdata.deadline = now_q;
        wdata.rel_time = now_q;
        we = in_fire && action_i == ActLoad && load_ok;
      end
      StRel: begin
        // release a due job
        if (rd.rel_left != 0 && now_q == rd.deadline) begin
          we = 1'b1;
          wdata.work = rd.burst;
          wdata.rel_time = now_q;
          wdata.rel_left = rd.rel_left - 16'd1;
          wdata.deadline = now_q + {16'd0, rd.period};
        end
      end
      StDrop: begin
        if (rd.work != 0 && late) begin
          we = 1'b1;
          wdata.work = '0;
        end
      end
      StRun: begin
        raddr = pick_q;
        waddr = pick_q;
        if (have_q && rd.work != 0) begin
          we = 1'b1;
          wdata.work = rd.work - 16'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      idx_q <= '0;
      pick_q <= '0;
      have_q <= 1'b0;
      pick_per_q <= '0;
      tc_q <= 4'd8;
      miss_now_q <= '0;
      now_q <= '0;
      miss_tot_q <= '0;
      run_q <= '0;
      idle_q <= 1'b1;
      fin_q <= 1'b0;
      wait_q <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          if (cfg_valid_i) tc_q <= cfg_data_i;
          if (in_fire) begin
            run_q <= '0;
            idle_q <= 1'b1;
            fin_q <= 1'b0;
            wait_q <= '0;
            miss_now_q <= '0;
            idx_q <= '0;
            have_q <= 1'b0;
            pick_q <= '0;
            if (action_i == ActLoad) state_q <= StOut;
            else if (n_act == 0) state_q <= StRun;
            else state_q <= StRel;
          end
        end
        StRel: begin
          if (rd.rel_left != 0 && now_q == rd.deadline && rd.work != 0) begin
            miss_tot_q <= miss_inc;
            miss_now_q <= now_inc;
          end
          idx_q <= last ? '0 : idx_q + 1'b1;
          if (last) state_q <= StPick;
        end
        StPick: begin
          // smallest period, ties to lower index
          if (rd.work != 0 && (!have_q || rd.period < pick_per_q)) begin
            have_q <= 1'b1;
            pick_q <= idx_q;
            pick_per_q <= rd.period;
          end
          idx_q <= last ? '0 : idx_q + 1'b1;
          if (last) state_q <= StDrop;
        end
        StDrop: begin
          if (rd.work != 0 && late) begin
            miss_tot_q <= miss_inc;
            miss_now_q <= now_inc;
          end
          idx_q <= last ? '0 : idx_q + 1'b1;
          if (last) state_q <= StRun;
        end
        StRun: begin
          if (have_q && rd.work != 0) begin
            run_q <= 3'(pick_q);
            idle_q <= 1'b0;
            if (rd.work == 16'd1) begin
              fin_q <= 1'b1;
              wait_q <= now_q + 32'd1 - rd.rel_time - {16'd0, rd.burst};
            end
          end
          now_q <= now_q + 32'd1;
          state_q <= StOut;
        end
        StOut: begin
          if (out_ready_i) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign running_task_o = run_q;
  assign idle_o = idle_q;
  assign job_finished_o = fin_q;
  assign job_wait_o = wait_q;
  assign missed_now_o = miss_now_q;
  assign missed_total_o = miss_tot_q;
  assign current_time_o = now_q;
endmodule

/* hw/rtl/rmd_task_table.sv */
// task table register file, one entry read and written per cycle
module rmd_task_table import rmd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              we_i,
  input  logic [IdxW-1:0]   waddr_i,
  input  task_entry_t       wdata_i,
  input  logic [IdxW-1:0]   raddr_i,
  output task_entry_t       rdata_o
);
  task_entry_t mem_q [MaxTasks];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxTasks; i++) mem_q[i] <= '0;
    end else if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[raddr_i];
endmodule

/* verif/rate_monotonic_dispatcher_unit_test.sv */
// testbench for the rate monotonic dispatcher: queued stimulus, reactive predictor, scoreboard
module rate_monotonic_dispatcher_unit_test;
  import rmd_pkg::*;

  typedef struct packed {
    logic        action;
    logic [2:0]  task_index;
    logic [15:0] burst_time;
    logic [15:0] period;
    logic [15:0] release_count;
  } sched_item_t;

  typedef struct packed {
    logic [2:0]  running_task;
    logic        idle;
    logic        job_finished;
    logic [31:0] job_wait;
    logic [3:0]  missed_now;
    logic [31:0] missed_total;
    logic [31:0] current_time;
  } sched_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        action_i = 1'b0;
  logic [2:0]  task_index_i = '0;
  logic [15:0] burst_time_i = '0;
  logic [15:0] period_i = '0;
  logic [15:0] release_count_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  running_task_o;
  logic        idle_o;
  logic        job_finished_o;
  logic [31:0] job_wait_o;
  logic [3:0]  missed_now_o;
  logic [31:0] missed_total_o;
  logic [31:0] current_time_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [3:0]  cfg_data_i = '0;

  rate_monotonic_dispatcher_unit uut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .action_i, .task_index_i,
    .burst_time_i, .period_i, .release_count_i, .out_valid_o, .out_ready_i,
    .running_task_o, .idle_o, .job_finished_o, .job_wait_o, .missed_now_o,
    .missed_total_o, .current_time_o, .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always #4 clk_i = ~clk_i;

  // predictor state, mirrors the task table of the block
  logic [15:0] p_burst [MaxTasks];
  logic [15:0] p_period [MaxTasks];
  logic [15:0] p_rel_left [MaxTasks];
  logic [15:0] p_work [MaxTasks];
  logic [31:0] p_deadline [MaxTasks];
  logic [31:0] p_rel_time [MaxTasks];
  logic [31:0] p_now;
  logic [31:0] p_miss_total;
  logic [3:0]  p_task_count;

  sched_item_t   pending_items[$];
  sched_result_t expected_results[$];
  int            fail_count = 0;
  bit            hold_sender = 1'b0;

  function automatic void note_miss(ref logic [3:0] tick_miss);
    if (p_miss_total != 32'hFFFF_FFFF) p_miss_total++;
    if (tick_miss < 4'd15) tick_miss++;
  endfunction

  // work out the one result of an accepted item and advance the predictor
  function automatic sched_result_t dispatch_step(sched_item_t it);
    sched_result_t r;
    int unsigned n;
    logic [3:0] tick_miss;
    bit have;
    int unsigned pick;
    r = '0;
    r.idle = 1'b1;
    tick_miss = '0;
    have = 1'b0;
    pick = 0;
    n = (p_task_count > MaxTasks) ? MaxTasks : p_task_count;
    if (it.action == ActLoad) begin
      if (it.task_index < MaxTasks) begin
        p_burst[it.task_index] = it.burst_time;
        p_period[it.task_index] = it.period;
        p_rel_left[it.task_index] = it.release_count;
        p_work[it.task_index] = '0;
        p_deadline[it.task_index] = p_now;
        p_rel_time[it.task_index] = p_now;
      end
    end else begin
      // release pass: an unfinished job at its next release is a miss
      for (int i = 0; i < n; i++) begin
        if (p_rel_left[i] != 0 && p_now == p_deadline[i]) begin
          if (p_work[i] != 0) note_miss(tick_miss);
          p_work[i] = p_burst[i];
          p_rel_time[i] = p_now;
          p_rel_left[i]--;
          p_deadline[i] = p_now + 32'(p_period[i]);
        end
      end
      // pick pass: smallest period, ties to lower index
      for (int i = 0; i < n; i++) begin
        if (p_work[i] != 0 && (!have || p_period[i] < p_period[pick])) begin
          have = 1'b1;
          pick = i;
        end
      end
      // drop pass: jobs that can no longer meet their deadline
      for (int i = 0; i < n; i++) begin
        if (p_work[i] != 0 && {32'd0, p_now} + 64'(p_work[i]) > {32'd0, p_deadline[i]}) begin
          p_work[i] = '0;
          note_miss(tick_miss);
        end
      end
      if (have && p_work[pick] != 0) begin
        r.running_task = pick[2:0];
        r.idle = 1'b0;
        p_work[pick]--;
        if (p_work[pick] == 0) begin
          r.job_finished = 1'b1;
          r.job_wait = (p_now + 1) - p_rel_time[pick] - 32'(p_burst[pick]);
        end
      end
      p_now++;
    end
    r.missed_now = tick_miss;
    r.missed_total = p_miss_total;
    r.current_time = p_now;
    return r;
  endfunction

  // driver: bursts of items with random gaps
  int burst_left = 0;
  int gap_left = 0;

  bit item_taken;
  always @(posedge clk_i) begin
    item_taken <= in_valid_i && in_ready_o;
    if (in_valid_i && in_ready_o) begin
      expected_results.push_back(dispatch_step(pending_items.pop_front()));
    end
  end

  // while held, the sender waits until every expected result has come
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || item_taken) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_items.size() > 0 &&
                     !(hold_sender && expected_results.size() > 0)) begin
          in_valid_i <= 1'b1;
          action_i <= pending_items[0].action;
          task_index_i <= pending_items[0].task_index;
          burst_time_i <= pending_items[0].burst_time;
          period_i <= pending_items[0].period;
          release_count_i <= pending_items[0].release_count;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 20);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stalls on its own pattern: phases of free flow and of random stall
  int stall_phase = 0;
  always @(negedge clk_i) begin
    stall_phase <= (stall_phase + 1) % 300;
    if (stall_phase < 100) out_ready_i <= 1'b1;
    else if (stall_phase < 200) out_ready_i <= ($urandom_range(0, 3) != 0);
    else out_ready_i <= ($urandom_range(0, 2) == 0);
  end

  // monitor and scoreboard
  always @(posedge clk_i) begin
    sched_result_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $error("result with no expectation waiting");
        fail_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (running_task_o !== exp_r.running_task) begin
          $error("running_task exp %0d got %0d", exp_r.running_task, running_task_o);
          fail_count++;
        end
        if (idle_o !== exp_r.idle) begin
          $error("idle exp %0d got %0d", exp_r.idle, idle_o);
          fail_count++;
        end
        if (job_finished_o !== exp_r.job_finished) begin
          $error("job_finished exp %0d got %0d", exp_r.job_finished, job_finished_o);
          fail_count++;
        end
        if (job_wait_o !== exp_r.job_wait) begin
          $error("job_wait exp %0d got %0d", exp_r.job_wait, job_wait_o);
          fail_count++;
        end
        if (missed_now_o !== exp_r.missed_now) begin
          $error("missed_now exp %0d got %0d", exp_r.missed_now, missed_now_o);
          fail_count++;
        end
        if (missed_total_o !== exp_r.missed_total) begin
          $error("missed_total exp %0d got %0d", exp_r.missed_total, missed_total_o);
          fail_count++;
        end
        if (current_time_o !== exp_r.current_time) begin
          $error("current_time exp %0d got %0d", exp_r.current_time, current_time_o);
          fail_count++;
        end
      end
    end
  end

  function automatic sched_item_t make_load(int idx, int b, int p, int c);
    sched_item_t it;
    it.action = ActLoad;
    it.task_index = idx[2:0];
    it.burst_time = b[15:0];
    it.period = p[15:0];
    it.release_count = c[15:0];
    return it;
  endfunction

  function automatic sched_item_t make_tick();
    sched_item_t it;
    it = '0;
    it.action = ActTick;
    // load fields are don't-care on ticks, toggle them anyway
    it.task_index = 3'($urandom);
    it.burst_time = 16'($urandom);
    it.period = 16'($urandom);
    it.release_count = 16'($urandom);
    return it;
  endfunction

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // register write while the block is idle
  task automatic write_task_count(logic [3:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    p_task_count = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // one random phase: loads, mostly with short bursts and periods, mixed with ticks
  task automatic queue_phase(int items);
    int made;
    made = 0;
    while (made < items) begin
      if ($urandom_range(0, 9) == 0) begin
        pending_items.push_back(make_load($urandom_range(0, 7), 16'($urandom),
                                          16'($urandom), 16'($urandom)));
      end else if ($urandom_range(0, 5) == 0) begin
        pending_items.push_back(make_load($urandom_range(0, 7), $urandom_range(0, 6),
                                          $urandom_range(0, 16), $urandom_range(0, 8)));
      end else begin
        pending_items.push_back(make_tick());
      end
      made++;
    end
  endtask

  initial begin
    for (int i = 0; i < MaxTasks; i++) begin
      p_burst[i] = '0; p_period[i] = '0; p_rel_left[i] = '0;
      p_work[i] = '0; p_deadline[i] = '0; p_rel_time[i] = '0;
    end
    p_now = '0;
    p_miss_total = '0;
    p_task_count = 4'd8;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, zero burst, zero period, miss on release, drop, ties
    pending_items.push_back(make_tick());
    pending_items.push_back(make_load(0, 2, 4, 3));
    pending_items.push_back(make_load(1, 2, 4, 2));
    pending_items.push_back(make_load(2, 0, 3, 2));
    pending_items.push_back(make_load(3, 5, 0, 1));
    pending_items.push_back(make_load(4, 4, 3, 2));
    pending_items.push_back(make_load(7, 65535, 65535, 65535));
    pending_items.push_back(make_load(5, 1, 1, 0));
    for (int i = 0; i < 14; i++) pending_items.push_back(make_tick());
    pending_items.push_back(make_load(0, 3, 5, 0));
    pending_items.push_back(make_tick());
    wait_drained();

    // several register settings, extremes included; the sender waits for
    // the block to drain before every write
    write_task_count(4'd1);
    queue_phase(80);
    wait_drained();
    write_task_count(4'd0);
    queue_phase(40);
    wait_drained();
    write_task_count(4'd15);
    queue_phase(120);
    wait_drained();
    write_task_count(4'd3);
    hold_sender = 1'b1;
    queue_phase(120);
    wait_drained();
    hold_sender = 1'b0;
    write_task_count(4'd8);
    queue_phase(200);
    wait_drained();
    write_task_count(4'd5);
    queue_phase(60);
    wait_drained();

    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end
endmodule

/* filelist.f */
hw/rtl/rmd_pkg.sv
hw/rtl/rmd_task_table.sv
hw/rtl/rate_monotonic_dispatcher_unit.sv
verif/rate_monotonic_dispatcher_unit_test.sv
